// ===== hw/rtl/lmvf_pkg.sv =====
// Package for the local mean and variance filter.
// Holds the channel payload types, register indexes, border codes and the
// command and status groups between controller and datapath. No dependencies.
package lmvf_pkg;

  // Fixed field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int VAR_BITS    = 31;
  localparam int DIM_BITS    = 11;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BORDER_MODE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BORDER_VALUE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  // Border handling codes.
  localparam logic [1:0] BORDER_CONSTANT  = 2'd0;
  localparam logic [1:0] BORDER_REPLICATE = 2'd1;
  localparam logic [1:0] BORDER_REFLECT   = 2'd2;
  localparam logic [1:0] BORDER_REFLECT101 = 2'd3;

  // Input operation codes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic [VAR_BITS-1:0]           window_variance;
    logic                          end_of_frame;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic check;
    logic setup;
    logic col_step;
    logic prod;
    logic diff;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;
    logic col_last;
    logic pipe_busy;
    logic div_busy;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hw/rtl/lmvf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lmvf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/lmvf_div.sv =====
// Iterative restoring divider, four quotient bits per cycle.
// Unsigned operands; no dependencies.
module lmvf_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int STEP  = 4;
  localparam int STEPS = (NUM_W + STEP - 1) / STEP;
  localparam int PW    = STEPS * STEP;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic [PW-1:0]    acc_q, acc_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNTW-1:0]  cnt_q;

  // Four shift and subtract steps per cycle.
  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    for (int i = 0; i < STEP; i++) begin
      rem_d = {rem_d[DEN_W-1:0], acc_d[PW-1]};
      acc_d = {acc_d[PW-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d = rem_d - {1'b0, den_q};
        acc_d[0] = 1'b1;
      end
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= PW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = acc_q[NUM_W-1:0];

endmodule

// ===== hw/rtl/lmvf_ctrl.sv =====
// Controller state machine of the local mean and variance filter.
// Depends on lmvf_pkg for the command and status groups.
module lmvf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lmvf_pkg::dp_status_t   status_i,
  output lmvf_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_SETUP   = 4'd2;
  localparam logic [3:0] S_COLS    = 4'd3;
  localparam logic [3:0] S_DRAIN   = 4'd4;
  localparam logic [3:0] S_PROD    = 4'd5;
  localparam logic [3:0] S_DIFF    = 4'd6;
  localparam logic [3:0] S_DIVGO   = 4'd7;
  localparam logic [3:0] S_DIVWAIT = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.pending ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_COLS;
      end
      S_COLS: begin
        cmd_o.col_step = 1'b1;
        if (status_i.col_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/lmvf_datapath.sv =====
// Datapath of the local mean and variance filter: configuration registers,
// position counters, row buffers, window accumulation, dividers, output register.
// Depends on lmvf_pkg, lmvf_ram and lmvf_div.
module lmvf_datapath #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lmvf_pkg::ctrl_cmd_t                   cmd_i,
  output lmvf_pkg::dp_status_t                  status_o,
  input  lmvf_pkg::in_t                         in_data_i,
  input  logic                                  cfg_we_i,
  input  logic [lmvf_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [lmvf_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output lmvf_pkg::out_t                        out_data_o
);

  localparam int SB    = lmvf_pkg::SAMPLE_BITS;
  localparam int HW    = lmvf_pkg::DIM_BITS;
  localparam int SR    = 2 * MAX_RADIUS + 1;
  localparam int SLW   = $clog2(SR);
  localparam int NMAX  = SR * SR;
  localparam int NW    = $clog2(NMAX + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = ((WW > HW) ? WW : HW) + 2;
  localparam int LINW  = HW + WW;
  localparam int SRW   = $clog2(SR + 1);
  localparam int SUMW  = SB + NW;
  localparam int SQW   = 2 * SB - 1;
  localparam int CSW   = SB + SRW;
  localparam int CQW   = SQW + SRW;
  localparam int SQSW  = SQW + NW;
  localparam int NVW   = SQSW + NW;
  localparam int SSQW  = 2 * SUMW;
  localparam int MNW   = SB + NW + 2;

  localparam logic signed [CW+1:0] S_ZERO = '0;
  localparam logic signed [CW+1:0] S_ONE  = (CW+2)'(1);
  localparam logic signed [CW+1:0] S_TWO  = (CW+2)'(2);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [1:0]          radius_q, mode_q;
  logic signed [SB-1:0] bval_q;
  logic [HW-1:0]       iw_q, ih_q;
  logic                geo_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 2'd1;
      mode_q   <= lmvf_pkg::BORDER_REFLECT101;
      bval_q   <= '0;
      iw_q     <= HW'(1024);
      ih_q     <= HW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lmvf_pkg::CFG_RADIUS:       radius_q <= cfg_data_i[1:0];
        lmvf_pkg::CFG_BORDER_MODE:  mode_q   <= cfg_data_i[1:0];
        lmvf_pkg::CFG_BORDER_VALUE: bval_q   <= $signed(cfg_data_i[SB-1:0]);
        lmvf_pkg::CFG_IMAGE_WIDTH:  iw_q     <= cfg_data_i[HW-1:0];
        lmvf_pkg::CFG_IMAGE_HEIGHT: ih_q     <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  assign geo_wr = cfg_we_i && ((cfg_index_i == lmvf_pkg::CFG_RADIUS) ||
                               (cfg_index_i == lmvf_pkg::CFG_IMAGE_WIDTH) ||
                               (cfg_index_i == lmvf_pkg::CFG_IMAGE_HEIGHT));

  // Effective geometry after range clamps.
  logic [RW-1:0] r_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW:0]   side;

  always_comb begin
    if (int'(radius_q) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_q);
    end
    if (iw_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(iw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw_q);
    end
    h_eff = (ih_q == '0) ? HW'(1) : ih_q;
    side  = {r_eff, 1'b1};
  end

  // Window size, its square and the result lag, kept in registers.
  logic [NW-1:0]     n_q;
  logic [2*NW-1:0]   nn_q;
  logic [LINW-1:0]   lag_q;
  logic [2*RW+1:0]   n_prod;

  assign n_prod = {{(RW+1){1'b0}}, side} * {{(RW+1){1'b0}}, side};

  always_ff @(posedge clk_i) begin
    n_q   <= NW'(n_prod);
    nn_q  <= {{NW{1'b0}}, n_q} * {{NW{1'b0}}, n_q};
    lag_q <= LINW'(r_eff) * LINW'(w_eff) + LINW'(r_eff);
  end

  // ---------------------------------------------------------------------------
  // Input and output position counters.
  logic [HW-1:0]   in_row_q, out_row_q;
  logic [AW-1:0]   in_col_q, out_col_q;
  logic [SLW-1:0]  in_slot_q, out_slot_q;
  logic [LINW-1:0] in_lin_q;
  logic            pending_q, pending_now;
  logic            in_frame, wr_en, in_col_wrap, out_col_wrap, last;
  logic [WW:0]     in_col_inc, out_col_inc;
  logic [HW:0]     out_row_inc;

  assign in_frame     = (in_row_q < h_eff);
  assign wr_en        = cmd_i.accept && in_frame &&
                        (in_data_i.operation == lmvf_pkg::OP_PUSH);
  assign in_col_inc   = (WW+1)'(in_col_q) + (WW+1)'(1);
  assign in_col_wrap  = (in_col_inc >= (WW+1)'(w_eff));
  assign out_col_inc  = (WW+1)'(out_col_q) + (WW+1)'(1);
  assign out_col_wrap = (out_col_inc >= (WW+1)'(w_eff));
  assign out_row_inc  = (HW+1)'(out_row_q) + (HW+1)'(1);
  assign last         = (out_row_inc >= (HW+1)'(h_eff)) && out_col_wrap;
  assign pending_now  = pending_q || !in_frame || (in_lin_q > lag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      in_lin_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      pending_q  <= 1'b0;
    end else if (geo_wr || (cmd_i.load_out && last)) begin
      // New frame.
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      in_lin_q   <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      pending_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && in_frame) begin
        in_lin_q <= in_lin_q + LINW'(1);
        if (in_col_wrap) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + HW'(1);
          in_slot_q <= (in_slot_q == SLW'(SR - 1)) ? '0 : in_slot_q + SLW'(1);
        end else begin
          in_col_q <= in_col_q + AW'(1);
        end
      end
      if (cmd_i.check) begin
        pending_q <= pending_now;
      end
      if (cmd_i.load_out) begin
        if (out_col_wrap) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + HW'(1);
          out_slot_q <= (out_slot_q == SLW'(SR - 1)) ? '0 : out_slot_q + SLW'(1);
        end else begin
          out_col_q <= out_col_q + AW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Border mapping of one window coordinate: returns {outside, index}.
  function automatic logic [CW:0] map_idx(logic signed [CW-1:0] x,
                                          logic [CW-1:0] n,
                                          logic [1:0] mode);
    logic signed [CW+1:0] xe;
    logic signed [CW+1:0] ne;
    logic signed [CW+1:0] m;
    logic                 bord;
    xe   = {{2{x[CW-1]}}, x};
    ne   = $signed({2'b00, n});
    m    = xe;
    bord = 1'b0;
    if ((xe < S_ZERO) || (xe >= ne)) begin
      unique case (mode)
        lmvf_pkg::BORDER_CONSTANT:  bord = 1'b1;
        lmvf_pkg::BORDER_REPLICATE: m = (xe < S_ZERO) ? S_ZERO : ne - S_ONE;
        lmvf_pkg::BORDER_REFLECT:   m = (xe < S_ZERO) ? -xe - S_ONE : (ne <<< 1) - S_ONE - xe;
        default:                    m = (xe < S_ZERO) ? -xe : (ne <<< 1) - S_TWO - xe;
      endcase
      if (m < S_ZERO) begin
        m = S_ZERO;
      end
      if (m > ne - S_ONE) begin
        m = ne - S_ONE;
      end
    end
    return {bord, m[CW-1:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Per-pixel row lanes: buffer slot, border flag and enable of each window row.
  logic [SLW-1:0] lane_slot_q [SR];
  logic [SLW-1:0] lane_slot_d [SR];
  logic [SR-1:0]  lane_rowb_q, lane_rowb_d, lane_en_q, lane_en_d;

  always_comb begin
    logic signed [CW-1:0] x;
    logic [CW:0]          mr;
    logic signed [CW:0]   s;
    for (int dr = 0; dr < SR; dr++) begin
      x  = $signed(CW'(out_row_q)) + $signed(CW'(dr)) - $signed(CW'(r_eff));
      mr = map_idx(x, CW'(h_eff), mode_q);
      s  = $signed((CW+1)'(out_slot_q)) + $signed({1'b0, mr[CW-1:0]}) -
           $signed((CW+1)'(out_row_q));
      if (s < 0) begin
        s = s + (CW+1)'(SR);
      end else if (s >= (CW+1)'(SR)) begin
        s = s - (CW+1)'(SR);
      end
      lane_slot_d[dr] = SLW'(s);
      lane_rowb_d[dr] = mr[CW];
      lane_en_d[dr]   = ((RW+1)'(dr) < side);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      lane_slot_q <= lane_slot_d;
      lane_rowb_q <= lane_rowb_d;
      lane_en_q   <= lane_en_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Column sweep: one window column is read from all row buffers each cycle.
  logic [RW:0]          dc_q;
  logic signed [CW-1:0] xc;
  logic [CW:0]          mc;
  logic [AW-1:0]        raddr;

  assign xc    = $signed(CW'(out_col_q)) + $signed(CW'(dc_q)) - $signed(CW'(r_eff));
  assign mc    = map_idx(xc, CW'(w_eff), mode_q);
  assign raddr = mc[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      dc_q <= '0;
    end else if (cmd_i.col_step) begin
      dc_q <= dc_q + (RW+1)'(1);
    end
  end

  // Row buffers, one per window row slot.
  logic [SB-1:0] bank_rd [SR];

  for (genvar b = 0; b < SR; b++) begin : g_bank
    lmvf_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (in_slot_q == SLW'(b))),
      .waddr_i (in_col_q),
      .wdata_i (in_data_i.sample),
      .raddr_i (raddr),
      .rdata_o (bank_rd[b])
    );
  end

  // Accumulation pipeline: read, lane select, square, column reduce, accumulate.
  logic                 p0_q, p1_q, p2_q, p3_q;
  logic                 p0_colb_q;
  logic signed [SB-1:0] lane_val_q [SR];
  logic [SQW-1:0]       sq_q [SR];
  logic signed [CSW-1:0] colsum_q, colsum2_q, colsum_d;
  logic [CQW-1:0]       sqcol_q, sqcol_d;
  logic signed [SUMW-1:0] sum_q;
  logic [SQSW-1:0]      sumsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= 1'b0;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      p3_q <= 1'b0;
    end else begin
      p0_q <= cmd_i.col_step;
      p1_q <= p0_q;
      p2_q <= p1_q;
      p3_q <= p2_q;
    end
  end

  always_comb begin
    colsum_d = '0;
    for (int i = 0; i < SR; i++) begin
      colsum_d = colsum_d + CSW'(lane_val_q[i]);
    end
    sqcol_d = '0;
    for (int i = 0; i < SR; i++) begin
      sqcol_d = sqcol_d + CQW'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [2*SB-1:0] p;
    p0_colb_q <= mc[CW];
    for (int i = 0; i < SR; i++) begin
      if (!lane_en_q[i]) begin
        lane_val_q[i] <= '0;
      end else if (p0_colb_q || lane_rowb_q[i]) begin
        lane_val_q[i] <= bval_q;
      end else begin
        lane_val_q[i] <= $signed(bank_rd[lane_slot_q[i]]);
      end
      p = lane_val_q[i] * lane_val_q[i];
      sq_q[i] <= SQW'(p);
    end
    colsum_q  <= colsum_d;
    colsum2_q <= colsum_q;
    sqcol_q   <= sqcol_d;
    if (cmd_i.setup) begin
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (p3_q) begin
      sum_q   <= sum_q + SUMW'(colsum2_q);
      sumsq_q <= sumsq_q + SQSW'(sqcol_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Final arithmetic: products, numerators, then two dividers in parallel.
  logic [NVW-1:0]  mula_q, vnum_q;
  logic [SSQW-1:0] mulb_q;
  logic [MNW-1:0]  mnum_q;
  logic signed [SSQW-1:0] sq_sum;

  assign sq_sum = sum_q * sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      mula_q <= NVW'(sumsq_q) * NVW'(n_q);
      mulb_q <= SSQW'(sq_sum);
      // Bias by 2n << SB keeps the mean numerator positive; it drops out of the low bits.
      mnum_q <= MNW'(((MNW+1)'(sum_q) <<< 1) + (MNW+1)'(n_q) +
                     ((MNW+1)'(n_q) << (SB + 1)));
    end
    if (cmd_i.diff) begin
      vnum_q <= NVW'(SSQW'(mula_q) - mulb_q);
    end
  end

  logic [NVW-1:0] vquo;
  logic [MNW-1:0] mquo;
  logic           vbusy, mbusy;

  lmvf_div #(
    .NUM_W (NVW),
    .DEN_W (2 * NW)
  ) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (vnum_q),
    .den_i   (nn_q),
    .busy_o  (vbusy),
    .quo_o   (vquo)
  );

  lmvf_div #(
    .NUM_W (MNW),
    .DEN_W (NW + 1)
  ) u_mdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (mnum_q),
    .den_i   ({n_q, 1'b0}),
    .busy_o  (mbusy),
    .quo_o   (mquo)
  );

  // ---------------------------------------------------------------------------
  // Output register; a result waits here until its transfer.
  logic out_valid_q;
  lmvf_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.window_mean     <= $signed(mquo[SB-1:0]);
      out_q.window_variance <= vquo[lmvf_pkg::VAR_BITS-1:0];
      out_q.end_of_frame    <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller.
  assign status_o.pending   = pending_now;
  assign status_o.col_last  = (dc_q == {r_eff, 1'b0});
  assign status_o.pipe_busy = p0_q || p1_q || p2_q || p3_q;
  assign status_o.div_busy  = vbusy || mbusy;
  assign status_o.out_full  = out_valid_q;

endmodule

// ===== hw/rtl/local_mean_variance_filter.sv =====
// Top level of the local mean and variance filter.
// Depends on lmvf_pkg, lmvf_ctrl and lmvf_datapath.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i   (lmvf_pkg::in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o  (lmvf_pkg::out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// An item that produces no result is taken and checked. An item with a result is
// taken, checked and set up, then each window column is read from the row buffers,
// the four-stage accumulation pipeline drains, the products and numerators are
// formed, two radix-16 dividers run side by side, and the output register is loaded.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. The row buffers are not cleared by reset;
// configuration is always accepted.
module local_mean_variance_filter #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lmvf_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lmvf_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lmvf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lmvf_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  lmvf_pkg::ctrl_cmd_t  cmd;
  lmvf_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lmvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmvf_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the local mean and variance filter.
// Depends on lmvf_pkg and local_mean_variance_filter; it drives random frames
// through the block and checks each window result against its own predictor.
module tb_top;

  localparam int STORE_ROWS = 7;
  localparam int STORE_COLS = 1024;
  localparam int LIMIT      = 20000;
  localparam int SETTLE     = 64;
  localparam int ITEMS      = 1500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  lmvf_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  lmvf_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lmvf_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [lmvf_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  local_mean_variance_filter uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow of the block state used to compute the expected windows.
  logic signed [15:0] pix_store [STORE_ROWS*STORE_COLS];
  bit pix_written [STORE_ROWS*STORE_COLS];
  int in_row, in_col, out_row, out_col;
  bit pending, frame_done;
  int win_radius = 1;
  logic [1:0] win_border = lmvf_pkg::BORDER_REFLECT101;
  logic signed [15:0] win_border_value = '0;
  int frame_width = 1024, frame_height = 1024;

  lmvf_pkg::out_t expected_windows [$];
  int mismatches = 0, windows_seen = 0, frames_seen = 0, items_sent = 0, phases = 0;
  bit hold_req = 1'b0;

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0; pending = 1'b0;
  endfunction

  // Folds a window coordinate into the frame; -1 selects the border value.
  function automatic int fold_index(int x, int n);
    if (x >= 0 && x < n) return x;
    unique case (win_border)
      lmvf_pkg::BORDER_CONSTANT:  return -1;
      lmvf_pkg::BORDER_REPLICATE: x = (x < 0) ? 0 : n - 1;
      lmvf_pkg::BORDER_REFLECT:   x = (x < 0) ? -x - 1 : 2*n - 1 - x;
      default:                    x = (x < 0) ? -x : 2*n - 2 - x;
    endcase
    if (x < 0) x = 0;
    if (x > n - 1) x = n - 1;
    return x;
  endfunction

  function automatic int eff_w();
    return (frame_width < 1) ? 1 : (frame_width > STORE_COLS ? STORE_COLS : frame_width);
  endfunction

  function automatic int eff_h();
    return (frame_height < 1) ? 1 : frame_height;
  endfunction

  // Advances the shadow state by one item and queues the window it completes.
  task automatic predict_window(input lmvf_pkg::in_t item);
    int w, h, lag, side, rr, cc;
    longint n, sum, sumsq, num, den, mean, var_q, v;
    lmvf_pkg::out_t res;
    w = eff_w(); h = eff_h();
    lag = win_radius*w + win_radius;
    side = 2*win_radius + 1;
    n = longint'(side*side);
    sum = 0; sumsq = 0;
    frame_done = 1'b0;
    if (in_row < h) begin
      if (item.operation == lmvf_pkg::OP_PUSH) begin
        pix_store[(in_row % STORE_ROWS)*STORE_COLS + in_col] = item.sample;
        pix_written[(in_row % STORE_ROWS)*STORE_COLS + in_col] = 1'b1;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
    end
    if (in_row >= h || in_row*w + in_col > lag) pending = 1'b1;
    if (!pending) return;
    for (int dr = 0; dr < side; dr++) begin
      rr = fold_index(out_row + dr - win_radius, h);
      for (int dc = 0; dc < side; dc++) begin
        cc = fold_index(out_col + dc - win_radius, w);
        if (rr < 0 || cc < 0) v = longint'(win_border_value);
        else v = longint'(pix_store[(rr % STORE_ROWS)*STORE_COLS + cc]);
        sum += v;
        sumsq += v*v;
      end
    end
    num = 2*sum + n;
    den = 2*n;
    mean = num / den;
    if (num % den != 0 && num < 0) mean--;
    var_q = (n*sumsq - sum*sum) / (n*n);
    res.window_mean = mean[15:0];
    res.window_variance = var_q[30:0];
    res.end_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_windows.push_back(res);
    if (res.end_of_frame) begin
      restart_frame();
      frame_done = 1'b1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0; out_row++;
      end
    end
  endtask

  // Input side: bursts of back-to-back transfers separated by idle gaps.
  int burst_left = 0;

  task automatic send_item(input lmvf_pkg::in_t item);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_window(item);
    items_sent++;
  endtask

  // Waits until every queued window has arrived and the block has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [lmvf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      lmvf_pkg::CFG_RADIUS: begin
        win_radius = int'(data[1:0]); restart_frame();
      end
      lmvf_pkg::CFG_BORDER_MODE:  win_border = data[1:0];
      lmvf_pkg::CFG_BORDER_VALUE: win_border_value = data;
      lmvf_pkg::CFG_IMAGE_WIDTH: begin
        frame_width = int'(data[10:0]); restart_frame();
      end
      lmvf_pkg::CFG_IMAGE_HEIGHT: begin
        frame_height = int'(data[10:0]); restart_frame();
      end
      default: ;
    endcase
  endtask

  // Writes all registers; unused upper data bits carry random noise.
  task automatic configure(input int rad, input logic [1:0] mode, input logic [15:0] bval,
                           input int w, input int h);
    logic [15:0] noise;
    noise = 16'($urandom);
    cfg_write(lmvf_pkg::CFG_RADIUS, {noise[15:2], rad[1:0]});
    cfg_write(lmvf_pkg::CFG_BORDER_MODE, {noise[13:0], mode});
    cfg_write(lmvf_pkg::CFG_BORDER_VALUE, bval);
    cfg_write(lmvf_pkg::CFG_IMAGE_WIDTH, {noise[4:0], w[10:0]});
    cfg_write(lmvf_pkg::CFG_IMAGE_HEIGHT, {noise[9:5], h[10:0]});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Builds the next item of a frame: mostly pushes inside the frame, flushes
  // only where the store already holds a sample, mostly flushes after it.
  function automatic lmvf_pkg::in_t next_item();
    lmvf_pkg::in_t it;
    it.sample = 16'($urandom);
    if (in_row < eff_h()) begin
      it.operation = lmvf_pkg::OP_PUSH;
      if ($urandom_range(0, 9) == 0 &&
          pix_written[(in_row % STORE_ROWS)*STORE_COLS + in_col]) begin
        it.operation = lmvf_pkg::OP_FLUSH;
      end
    end else begin
      it.operation = ($urandom_range(0, 4) == 0) ? lmvf_pkg::OP_PUSH : lmvf_pkg::OP_FLUSH;
    end
    return it;
  endfunction

  // Directed small frames, mostly of a single pixel; a known row checks the window by value.
  typedef struct {
    int rad; logic [1:0] mode; logic [15:0] bval; int w; int h;
    logic [15:0] pix; bit known; logic [15:0] mean;
  } directed_row_t;

  directed_row_t directed_rows [12] = '{
    '{0, lmvf_pkg::BORDER_CONSTANT,   16'h0000, 1, 1, 16'h7FFF, 1, 16'h7FFF},
    '{0, lmvf_pkg::BORDER_REPLICATE,  16'h0000, 1, 1, 16'h8000, 1, 16'h8000},
    '{0, lmvf_pkg::BORDER_REFLECT,    16'h0000, 1, 1, 16'h0000, 1, 16'h0000},
    '{0, lmvf_pkg::BORDER_REFLECT101, 16'h0000, 1, 1, 16'hFFFF, 1, 16'hFFFF},
    '{3, lmvf_pkg::BORDER_REPLICATE,  16'h0000, 1, 1, 16'h7FFF, 1, 16'h7FFF},
    '{3, lmvf_pkg::BORDER_REPLICATE,  16'h0000, 1, 1, 16'h8000, 1, 16'h8000},
    '{2, lmvf_pkg::BORDER_REFLECT,    16'h1234, 1, 1, 16'h0100, 1, 16'h0100},
    '{1, lmvf_pkg::BORDER_REFLECT101, 16'h0000, 0, 0, 16'hFF00, 1, 16'hFF00},
    '{1, lmvf_pkg::BORDER_CONSTANT,   16'h00A5, 1, 1, 16'h00A5, 1, 16'h00A5},
    '{3, lmvf_pkg::BORDER_CONSTANT,   16'h8000, 1, 1, 16'h7FFF, 0, 16'h0000},
    '{3, lmvf_pkg::BORDER_CONSTANT,   16'h7FFF, 3, 2, 16'h8000, 0, 16'h0000},
    '{3, lmvf_pkg::BORDER_REFLECT,    16'h0000, 5, 3, 16'h4321, 0, 16'h0000}
  };

  // Stimulus: directed frames, then random phases of whole and broken frames.
  initial begin
    lmvf_pkg::in_t it;
    lmvf_pkg::out_t known_res;
    int rad, w, h, nframes, stop_at;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    restart_frame();
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      configure(directed_rows[i].rad, directed_rows[i].mode, directed_rows[i].bval,
                directed_rows[i].w, directed_rows[i].h);
      phases++;
      it.operation = lmvf_pkg::OP_PUSH;
      it.sample = directed_rows[i].pix;
      do begin
        send_item(it);
        if (directed_rows[i].known && frame_done) begin
          // A uniform window gives the pixel itself and no variance.
          known_res.window_mean = directed_rows[i].mean;
          known_res.window_variance = '0;
          known_res.end_of_frame = 1'b1;
          void'(expected_windows.pop_back());
          expected_windows.push_back(known_res);
        end
        it = next_item();
      end while (!frame_done);
      settle();
    end

    items_sent = 0;
    while (items_sent < ITEMS) begin
      rad = $urandom_range(0, 3);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      nframes = $urandom_range(1, 3);
      unique case (phases % 9)
        3: begin w = 1; h = $urandom_range(20, 60); end
        5: begin w = 0; h = 0; end
        7: begin rad = 3; w = $urandom_range(1, 6); end
        default: ;
      endcase
      // One long row wider than the buffers checks the width clamp.
      if (phases == 13) begin w = 2047; h = 0; rad = 0; nframes = 1; end
      configure(rad, 2'($urandom_range(0, 3)), 16'($urandom), w, h);
      phases++;
      // One phase in six may end in the middle of a frame.
      stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, eff_w()*eff_h()) : -1;
      for (int f = 0; f < nframes; f++) begin
        do begin
          if (items_sent == 750) hold_req = 1'b1;
          send_item(next_item());
          if (stop_at > 0) stop_at--;
        end while (!frame_done && stop_at != 0);
        if (stop_at == 0) break;
      end
      settle();
    end

    $display("Covered %0d configuration phases, %0d windows in %0d frames.",
             phases, windows_seen, frames_seen);
    $display("All radii and border modes were used, with stalls on both sides.");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Output side: random stalls, runs of full throughput, one long hold-off.
  int hold_cnt = 0;
  int ready_mode = 0;
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if ($urandom_range(0, 99) == 0) ready_mode = $urandom_range(0, 2);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (ready_mode == 0) begin
      out_ready_i <= 1'b1;
    end else if (ready_mode == 1) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // Compares every window transfer with the oldest expectation.
  always @(posedge clk_i) begin
    lmvf_pkg::out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      windows_seen++;
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected window: %p", out_data_o);
      end else begin
        exp_res = expected_windows.pop_front();
        if (exp_res.end_of_frame) frames_seen++;
        if (out_data_o !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Window mismatch: mean %h/%h var %h/%h eof %b/%b (exp/act)",
                     exp_res.window_mean, out_data_o.window_mean,
                     exp_res.window_variance, out_data_o.window_variance,
                     exp_res.end_of_frame, out_data_o.end_of_frame);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Timeout with %0d windows outstanding.", expected_windows.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule
